>>> rtl/rwo_pkg.sv
// ----------------------------------------------------------------------------
// rwo_pkg - shared types and constants of the random wander controller
// Mode and command codes, register indexes, request structs and the fixed
// widths of the current samples, tick counter and run length.
// ----------------------------------------------------------------------------
`default_nettype none

package rwo_pkg;

	// field widths
	localparam int CURRENT_BITS = 12;
	localparam int TICK_BITS    = 8;
	localparam int DRAW_BITS    = 16;
	localparam int RUN_BITS     = 5;
	localparam int CFG_BITS     = 12;
	localparam int CODE_BITS    = 3;

	localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

	// register reset values
	localparam logic [TICK_BITS-1:0]    RST_COLLISION_DELAY = TICK_BITS'(10);
	localparam logic [CURRENT_BITS-1:0] RST_FWD_LIMIT       = CURRENT_BITS'(2048);
	localparam logic [CURRENT_BITS-1:0] RST_REV_LIMIT       = CURRENT_BITS'(2048);
	localparam logic [TICK_BITS-1:0]    RST_TURN_STEPS      = TICK_BITS'(5);
	localparam logic [RUN_BITS-1:0]     RST_RUN_LIMIT       = RUN_BITS'(3);

	// run lengths and choice thresholds
	localparam logic [RUN_BITS-1:0] RUN_BASE     = RUN_BITS'(5);
	localparam logic [7:0]          CHOICE_MOD   = 8'd100;
	localparam logic [7:0]          CHOICE_REV   = 8'd66;
	localparam logic [7:0]          CHOICE_RIGHT = 8'd33;
	localparam logic [7:0]          CHOICE_HALF  = 8'd50;
	// floor(2^19 / 100), slightly low so the quotient estimate never overshoots
	localparam logic [12:0]         RECIP_100    = 13'd5242;
	localparam int                  RECIP_SHIFT  = 19;

	// register indexes
	typedef enum logic [1:0] {
		REG_COLLISION_DELAY = 2'd0,
		REG_FWD_LIMIT       = 2'd1,
		REG_REV_LIMIT       = 2'd2,
		REG_TURN_STEPS      = 2'd3
	} cfg_reg_t;

	// wander modes
	typedef enum logic [CODE_BITS-1:0] {
		MODE_FWD   = 3'd0,
		MODE_REV   = 3'd1,
		MODE_RIGHT = 3'd2,
		MODE_LEFT  = 3'd3,
		MODE_NONE  = 3'd4
	} mode_t;

	// motor commands
	typedef enum logic [CODE_BITS-1:0] {
		CMD_NONE  = 3'd0,
		CMD_FWD   = 3'd1,
		CMD_REV   = 3'd2,
		CMD_RIGHT = 3'd3,
		CMD_LEFT  = 3'd4
	} cmd_t;

	typedef struct packed {
		logic                    sonar_obstacle;
		logic [CURRENT_BITS-1:0] current_right;
		logic [CURRENT_BITS-1:0] current_left;
		logic [DRAW_BITS-1:0]    duration_draw;
		logic [DRAW_BITS-1:0]    choice_draw;
	} in_item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] motor_command;
		logic [CODE_BITS-1:0] active_mode;
		logic [CODE_BITS-1:0] pending_mode;
	} out_item_t;

	// tick with its random draws already reduced
	typedef struct packed {
		logic                    sonar_obstacle;
		logic [CURRENT_BITS-1:0] current_right;
		logic [CURRENT_BITS-1:0] current_left;
		logic [RUN_BITS-1:0]     run_fwd;
		logic [RUN_BITS-1:0]     run_rev;
		mode_t                   pick_fwd;
		mode_t                   pick_rev;
	} tick_t;

	typedef struct packed {
		logic [TICK_BITS-1:0]    collision_check_delay;
		logic [CURRENT_BITS-1:0] forward_current_limit;
		logic [CURRENT_BITS-1:0] reverse_current_limit;
		logic [TICK_BITS-1:0]    turn_steps;
	} cfg_t;

	// command issued on entry to a mode
	function automatic cmd_t mode_to_cmd(input mode_t m);
		cmd_t c;
		unique case (m)
			MODE_FWD:   c = CMD_FWD;
			MODE_REV:   c = CMD_REV;
			MODE_RIGHT: c = CMD_RIGHT;
			MODE_LEFT:  c = CMD_LEFT;
			default:    c = CMD_NONE;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rwo_reduce.sv
// ----------------------------------------------------------------------------
// rwo_reduce - random draw reduction
// Turns the two random words of a request into run lengths (mod 15, mod 5)
// and the next-mode picks (mod 100), ahead of the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module rwo_reduce (
	input  rwo_pkg::in_item_t item,
	output rwo_pkg::tick_t    tick
);

	logic [5:0]  nib_sum;
	logic [4:0]  nib_fold;
	logic [3:0]  dur_mod15;
	logic [2:0]  dur_mod5;
	logic [28:0] quot_prod;
	logic [9:0]  quot_est;
	logic [16:0] quot_x100;
	logic [16:0] rem_raw;
	logic [7:0]  rem_lo;
	logic [7:0]  choice_mod;

	// mod 15: 16 = 1 (mod 15), so add the nibbles and fold once
	assign nib_sum  = 6'(item.duration_draw[3:0]) + 6'(item.duration_draw[7:4])
		+ 6'(item.duration_draw[11:8]) + 6'(item.duration_draw[15:12]);
	assign nib_fold = 5'(nib_sum[5:4]) + 5'(nib_sum[3:0]);
	assign dur_mod15 = (nib_fold >= 5'd15) ? 4'(nib_fold - 5'd15) : nib_fold[3:0];

	// mod 5 of a value below 15
	always_comb begin
		if (dur_mod15 >= 4'd10) begin
			dur_mod5 = 3'(dur_mod15 - 4'd10);
		end else if (dur_mod15 >= 4'd5) begin
			dur_mod5 = 3'(dur_mod15 - 4'd5);
		end else begin
			dur_mod5 = dur_mod15[2:0];
		end
	end

	// mod 100 by reciprocal; the estimate is at most one short
	assign quot_prod  = 29'(item.choice_draw) * 29'(rwo_pkg::RECIP_100);
	assign quot_est   = quot_prod[28:rwo_pkg::RECIP_SHIFT];
	assign quot_x100  = (17'(quot_est) << 6) + (17'(quot_est) << 5) + (17'(quot_est) << 2);
	assign rem_raw    = 17'(item.choice_draw) - quot_x100;
	assign rem_lo     = rem_raw[7:0];
	assign choice_mod = (rem_lo >= rwo_pkg::CHOICE_MOD) ? (rem_lo - rwo_pkg::CHOICE_MOD) : rem_lo;

	// tick assembly
	always_comb begin
		tick.sonar_obstacle = item.sonar_obstacle;
		tick.current_right  = item.current_right;
		tick.current_left   = item.current_left;
		tick.run_fwd        = rwo_pkg::RUN_BASE + rwo_pkg::RUN_BITS'(dur_mod15);
		tick.run_rev        = rwo_pkg::RUN_BASE + rwo_pkg::RUN_BITS'(dur_mod5);
		if (choice_mod >= rwo_pkg::CHOICE_REV) begin
			tick.pick_fwd = rwo_pkg::MODE_REV;
		end else if (choice_mod >= rwo_pkg::CHOICE_RIGHT) begin
			tick.pick_fwd = rwo_pkg::MODE_RIGHT;
		end else begin
			tick.pick_fwd = rwo_pkg::MODE_LEFT;
		end
		tick.pick_rev = (choice_mod >= rwo_pkg::CHOICE_HALF) ? rwo_pkg::MODE_RIGHT
			: rwo_pkg::MODE_LEFT;
	end

endmodule

`default_nettype wire

>>> rtl/rwo_step.sv
// ----------------------------------------------------------------------------
// rwo_step - wander mode state machine
// Holds the active and pending mode, the tick count and the run length,
// and works out one tick's result from the registered request.
// ----------------------------------------------------------------------------
`default_nettype none

module rwo_step (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  rwo_pkg::tick_t     tick,
	input  rwo_pkg::cfg_t      cfg,
	output rwo_pkg::out_item_t result
);

	rwo_pkg::mode_t                mode_now_q;
	rwo_pkg::mode_t                mode_next_q;
	logic [rwo_pkg::TICK_BITS-1:0] elapsed_q;
	logic [rwo_pkg::RUN_BITS-1:0]  run_limit_q;

	rwo_pkg::mode_t                active_d;
	rwo_pkg::mode_t                pend_d;
	logic [rwo_pkg::TICK_BITS-1:0] elapsed_d;
	logic [rwo_pkg::RUN_BITS-1:0]  run_d;
	rwo_pkg::cmd_t                 cmd_d;
	logic                          entering;
	logic                          settled;
	logic                          blk_fwd;
	logic                          blk_rev;
	logic                          run_done;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_now_q  <= rwo_pkg::MODE_NONE;
			mode_next_q <= rwo_pkg::MODE_FWD;
			elapsed_q   <= '0;
			run_limit_q <= rwo_pkg::RST_RUN_LIMIT;
		end else if (advance) begin
			mode_now_q  <= active_d;
			mode_next_q <= pend_d;
			elapsed_q   <= elapsed_d;
			run_limit_q <= run_d;
		end
	end

	assign entering = (mode_now_q == rwo_pkg::MODE_NONE) && (mode_next_q != rwo_pkg::MODE_NONE);

	// mode entry and tick count
	always_comb begin
		active_d  = mode_now_q;
		pend_d    = mode_next_q;
		elapsed_d = elapsed_q;
		run_d     = run_limit_q;
		cmd_d     = rwo_pkg::CMD_NONE;
		if (entering) begin
			active_d  = mode_next_q;
			pend_d    = rwo_pkg::MODE_NONE;
			elapsed_d = '0;
			cmd_d     = rwo_pkg::mode_to_cmd(mode_next_q);
			if (mode_next_q == rwo_pkg::MODE_FWD) begin
				run_d = tick.run_fwd;
			end else if (mode_next_q == rwo_pkg::MODE_REV) begin
				run_d = tick.run_rev;
			end
		end else if (mode_now_q != rwo_pkg::MODE_NONE && elapsed_q != rwo_pkg::TICK_MAX) begin
			elapsed_d = elapsed_q + 1'b1;
		end

		// exit tests on the mode that is active this tick
		settled  = elapsed_d > cfg.collision_check_delay;
		blk_fwd  = settled && (tick.current_right > cfg.forward_current_limit
			|| tick.current_left > cfg.forward_current_limit);
		blk_rev  = settled && (tick.current_right > cfg.reverse_current_limit
			|| tick.current_left > cfg.reverse_current_limit);
		run_done = elapsed_d >= rwo_pkg::TICK_BITS'(run_d);

		unique case (active_d)
			rwo_pkg::MODE_FWD: begin
				if (blk_fwd) begin
					pend_d   = rwo_pkg::MODE_REV;
					active_d = rwo_pkg::MODE_NONE;
				end else if (tick.sonar_obstacle || run_done) begin
					pend_d   = tick.pick_fwd;
					active_d = rwo_pkg::MODE_NONE;
				end
			end
			rwo_pkg::MODE_REV: begin
				if (blk_rev) begin
					pend_d   = rwo_pkg::MODE_FWD;
					active_d = rwo_pkg::MODE_NONE;
				end else if (run_done) begin
					pend_d   = tick.pick_rev;
					active_d = rwo_pkg::MODE_NONE;
				end
			end
			rwo_pkg::MODE_RIGHT, rwo_pkg::MODE_LEFT: begin
				if (tick.sonar_obstacle) begin
					pend_d   = rwo_pkg::MODE_REV;
					active_d = rwo_pkg::MODE_NONE;
				end else if (elapsed_d >= cfg.turn_steps) begin
					pend_d   = rwo_pkg::MODE_FWD;
					active_d = rwo_pkg::MODE_NONE;
				end
			end
			default: begin
			end
		endcase

		result.motor_command = cmd_d;
		result.active_mode   = active_d;
		result.pending_mode  = pend_d;
	end

`ifndef SYNTHESIS
	// exactly one of active and pending is a real mode between ticks
	a_one_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_now_q == rwo_pkg::MODE_NONE) != (mode_next_q == rwo_pkg::MODE_NONE))
		else $error("rwo_step: active and pending modes disagree");

	// entry clears the tick count
	a_entry_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && entering |=> elapsed_q == '0)
		else $error("rwo_step: tick count not cleared on entry");

	// a command only goes out on an entry tick
	a_cmd_entry: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !entering |-> result.motor_command == rwo_pkg::CMD_NONE)
		else $error("rwo_step: motor command without mode entry");

	// an active mode counts one tick per request until saturation
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && mode_now_q != rwo_pkg::MODE_NONE && elapsed_q != rwo_pkg::TICK_MAX
		|=> elapsed_q == $past(elapsed_q) + 1'b1)
		else $error("rwo_step: tick count did not advance");
`endif

endmodule

`default_nettype wire

>>> rtl/random_wander_obstacle_fsm.sv
// ----------------------------------------------------------------------------
// random_wander_obstacle_fsm - random wander controller, top level
// Each request on the input channel is one control tick: sonar flag, both
// motor currents and two random words. Each tick returns one result with
// the motor command (non-zero only on mode entry), the active mode and the
// pending mode. Four registers set the settling delay, the forward and
// reverse current limits and the turn length; write them while idle.
// The random words are reduced into the input register and the mode logic
// then fills the result register from it. One tick is accepted every cycle
// while the result register is free; the mode state feeds back through
// combinational logic only, so nothing else limits the rate.
// When the receiver stalls, the result register holds and the input
// register takes one more request before in_ready falls.
// Reset (arst_n low) clears both pipeline registers, sets the registers to
// their defaults and leaves forward pending with no mode active.
// ----------------------------------------------------------------------------
`default_nettype none

module random_wander_obstacle_fsm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  rwo_pkg::in_item_t                in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output rwo_pkg::out_item_t               out_data,
	input  logic                             cfg_we,
	input  logic [1:0]                       cfg_index,
	input  logic [rwo_pkg::CFG_BITS-1:0]     cfg_data
);

	rwo_pkg::cfg_t      cfg_q;
	rwo_pkg::tick_t     tick_in;
	rwo_pkg::tick_t     tick_s1;
	logic               valid_s1;
	rwo_pkg::out_item_t result;
	rwo_pkg::out_item_t out_data_q;
	logic               out_valid_q;
	logic               advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.collision_check_delay <= rwo_pkg::RST_COLLISION_DELAY;
			cfg_q.forward_current_limit <= rwo_pkg::RST_FWD_LIMIT;
			cfg_q.reverse_current_limit <= rwo_pkg::RST_REV_LIMIT;
			cfg_q.turn_steps            <= rwo_pkg::RST_TURN_STEPS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rwo_pkg::REG_COLLISION_DELAY:
					cfg_q.collision_check_delay <= cfg_data[rwo_pkg::TICK_BITS-1:0];
				rwo_pkg::REG_FWD_LIMIT:
					cfg_q.forward_current_limit <= cfg_data[rwo_pkg::CURRENT_BITS-1:0];
				rwo_pkg::REG_REV_LIMIT:
					cfg_q.reverse_current_limit <= cfg_data[rwo_pkg::CURRENT_BITS-1:0];
				rwo_pkg::REG_TURN_STEPS:
					cfg_q.turn_steps <= cfg_data[rwo_pkg::TICK_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// handshake: the pipeline moves when the result register is free
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	rwo_reduce u_reduce (
		.item (in_data),
		.tick (tick_in)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tick_s1 <= tick_in;
		end
	end

	rwo_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.tick    (tick_s1),
		.cfg     (cfg_q),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire
